[rtl/core/cnsd_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cnsd_pkg: shared types for the chromatic number subset solver
// Item structs, operation and result codes, and the sequencer states.
// ---------------------------------------------------------------------------
package cnsd_pkg;

  // Operation codes of an input item.
  localparam logic OP_EDGE  = 1'b0;
  localparam logic OP_SOLVE = 1'b1;

  // Result kinds.
  localparam logic KIND_COUNT  = 1'b0;
  localparam logic KIND_COLOUR = 1'b1;

  // Effective vertex count after reset.
  localparam logic [4:0] VCOUNT_RESET = 5'd16;

  // Hard cap set by the 4-bit vertex fields.
  localparam int unsigned VERT_CAP = 16;

  typedef struct packed {
    logic       op;
    logic [3:0] vertex_a;
    logic [3:0] vertex_b;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [3:0] vertex;
    logic [4:0] value;
    logic       last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_IND_RD,
    ST_IND_WR,
    ST_DP_RD,
    ST_DP_FIN,
    ST_TR_RD,
    ST_TR_WR,
    ST_EMIT
  } state_e;

endpackage

[rtl/core/cnsd_out_stage.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cnsd_out_stage: result output register
// Holds one result until the receiver takes it and reports when a new
// result can be loaded.
// ---------------------------------------------------------------------------
module cnsd_out_stage
  import cnsd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  out_item_t item_i,
  output logic      ready_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      valid_q, valid_d;
  out_item_t item_q;

  // The register is free when empty or when its result transfers now.
  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      item_q <= item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

[rtl/core/chromatic_number_subset_dp.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chromatic_number_subset_dp: exact chromatic number by subset DP
// Loads edges, then solves and reports the chromatic number and a colouring.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel takes edge items and solve items. An edge item is
//   absorbed in the cycle of its transfer, so edges load one per cycle
//   while idle. A solve item holds in_stall_o high until its last result
//   is loaded into the output register. The solve runs through three
//   per-mask memories: it marks the independent sets mask by mask, scans
//   every nonempty submask of every mask to keep the fewest colours and
//   the chosen class, traces the classes back from the full mask and sends
//   n+1 results, where n is the effective vertex count.
//   Results come out as the chromatic number, then one colour per vertex in
//   vertex order, the last flagged by last. A stalled receiver holds the
//   output register and pauses the result sequence; the adjacency matrix is
//   cleared when the last result is loaded.
//   Reset clears the adjacency matrix and sets the vertex count to 16; the
//   memories are not cleared, each solve writes every entry before use.
//   The user writes vertex_count via cfg_we_i / cfg_data_i only while idle; the block leaves it unchecked.
// ---------------------------------------------------------------------------
module chromatic_number_subset_dp
  import cnsd_pkg::*;
#(
  parameter int unsigned MAX_NODES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_item_o
);

  localparam int unsigned NV    = (MAX_NODES < VERT_CAP) ? MAX_NODES : VERT_CAP;
  localparam int unsigned IW    = $clog2(NV);
  localparam int unsigned DEPTH = 1 << NV;

  // Lowest set bit index of a mask.
  function automatic logic [IW-1:0] low_index(input logic [NV-1:0] m);
    logic [IW-1:0] r;
    r = '0;
    for (int i = NV - 1; i >= 0; i--) begin
      if (m[i]) r = IW'(i);
    end
    return r;
  endfunction

  state_e        state_q, state_d;
  logic [4:0]    vcount_q;
  logic [NV-1:0] adj_q [NV];
  logic [NV-1:0] adj_d [NV];
  logic [3:0]    colour_of_q [NV];
  logic [3:0]    colour_of_d [NV];
  logic [NV-1:0] mask_q, mask_d;
  logic [NV-1:0] sub_q, sub_d;
  logic [NV-1:0] cur_q, cur_d;
  logic [NV-1:0] pick_q, pick_d;
  logic [4:0]    best_q, best_d;
  logic [4:0]    chrom_q, chrom_d;
  logic [4:0]    colour_q, colour_d;
  logic [4:0]    emit_k_q, emit_k_d;
  logic          p_valid_q, p_valid_d;

  // Effective vertex count and full mask.
  logic [4:0]    n_eff;
  logic [NV-1:0] full;
  always_comb begin
    n_eff = vcount_q;
    if (n_eff == 5'd0) n_eff = 5'd1;
    if (n_eff > 5'(NV)) n_eff = 5'(NV);
    for (int i = 0; i < NV; i++) begin
      full[i] = (5'(i) < n_eff);
    end
  end

  // Memories: independence flags, minimum colour counts, chosen classes.
  logic            ind_mem [DEPTH];
  logic [4:0]      min_mem [DEPTH];
  logic [NV-1:0]   best_mem [DEPTH];
  logic            ind_we, min_we, best_we;
  logic            ind_wd;
  logic [4:0]      min_wd;
  logic [NV-1:0]   ind_wa, min_wa, ind_ra, min_ra;
  logic            ind_rd_q;
  logic [4:0]      min_rd_q;
  logic [NV-1:0]   best_rd_q;

  always_ff @(posedge clk_i) begin
    if (ind_we) ind_mem[ind_wa] <= ind_wd;
    ind_rd_q <= ind_mem[ind_ra];
  end

  always_ff @(posedge clk_i) begin
    if (min_we) min_mem[min_wa] <= min_wd;
    min_rd_q <= min_mem[min_ra];
  end

  // Submask candidate from the read issued last cycle.
  logic [NV-1:0] rest;
  logic [4:0]    cand;
  logic          hit;
  logic [4:0]    best_c;
  logic [NV-1:0] pick_c;
  logic [NV-1:0] cls;
  logic [NV-1:0] mask_inc;
  logic          out_ready;
  logic          out_load;
  out_item_t     out_item;
  logic [NV-1:0] sub_prev_q;

  assign rest     = mask_q & (mask_q - 1'b1);
  assign cand     = min_rd_q + 5'd1;
  assign hit      = p_valid_q && ind_rd_q && (cand < best_q);
  assign best_c   = hit ? cand : best_q;
  assign pick_c   = hit ? sub_prev_q : pick_q;
  assign cls      = best_rd_q & cur_q;
  assign mask_inc = mask_q + 1'b1;

  // Submask that the pending read belongs to.
  always_ff @(posedge clk_i) begin
    sub_prev_q <= sub_q;
  end

  always_ff @(posedge clk_i) begin
    if (best_we) best_mem[mask_q] <= pick_c;
    best_rd_q <= best_mem[cur_q];
  end

  // Result being offered to the output register.
  always_comb begin
    out_item.kind   = (emit_k_q == 5'd0) ? KIND_COUNT : KIND_COLOUR;
    out_item.vertex = (emit_k_q == 5'd0) ? 4'd0 : 4'(emit_k_q - 5'd1);
    out_item.value  = (emit_k_q == 5'd0) ? chrom_q
                      : {1'b0, colour_of_q[IW'(emit_k_q - 5'd1)]};
    out_item.last   = (emit_k_q == n_eff);
  end

  // Sequencer: next state, memory accesses and datapath updates.
  always_comb begin
    state_d     = state_q;
    adj_d       = adj_q;
    colour_of_d = colour_of_q;
    mask_d      = mask_q;
    sub_d       = sub_q;
    cur_d       = cur_q;
    pick_d      = pick_q;
    best_d      = best_q;
    chrom_d     = chrom_q;
    colour_d    = colour_q;
    emit_k_d    = emit_k_q;
    p_valid_d   = 1'b0;
    ind_we      = 1'b0;
    ind_wa      = mask_q;
    ind_wd      = 1'b0;
    min_we      = 1'b0;
    min_wa      = mask_q;
    min_wd      = best_c;
    best_we     = 1'b0;
    ind_ra      = sub_q;
    min_ra      = mask_q ^ sub_q;
    out_load    = 1'b0;
    in_stall_o  = (state_q != ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_item_i.op == OP_SOLVE) begin
            state_d = ST_INIT;
          end else if ((in_item_i.vertex_a != in_item_i.vertex_b) &&
                       ({1'b0, in_item_i.vertex_a} < n_eff) &&
                       ({1'b0, in_item_i.vertex_b} < n_eff)) begin
            adj_d[in_item_i.vertex_a[IW-1:0]][in_item_i.vertex_b[IW-1:0]] = 1'b1;
            adj_d[in_item_i.vertex_b[IW-1:0]][in_item_i.vertex_a[IW-1:0]] = 1'b1;
          end
        end
      end
      ST_INIT: begin
        // Empty set: independent, zero colours.
        ind_we = 1'b1;
        ind_wa = '0;
        ind_wd = 1'b1;
        min_we = 1'b1;
        min_wa = '0;
        min_wd = 5'd0;
        for (int i = 0; i < NV; i++) colour_of_d[i] = 4'd0;
        mask_d  = NV'(1);
        state_d = ST_IND_RD;
      end
      ST_IND_RD: begin
        ind_ra  = rest;
        state_d = ST_IND_WR;
      end
      ST_IND_WR: begin
        ind_we = 1'b1;
        ind_wd = ind_rd_q && ((adj_q[low_index(mask_q)] & rest) == '0);
        if (mask_q == full) begin
          mask_d  = NV'(1);
          sub_d   = NV'(1);
          best_d  = n_eff + 5'd1;
          pick_d  = NV'(1);
          state_d = ST_DP_RD;
        end else begin
          mask_d  = mask_inc;
          state_d = ST_IND_RD;
        end
      end
      ST_DP_RD: begin
        // Issue one submask a cycle and fold in the previous one.
        best_d    = best_c;
        pick_d    = pick_c;
        p_valid_d = 1'b1;
        sub_d     = (sub_q - 1'b1) & mask_q;
        if (sub_d == '0) state_d = ST_DP_FIN;
      end
      ST_DP_FIN: begin
        min_we  = 1'b1;
        best_we = 1'b1;
        if (mask_q == full) begin
          chrom_d  = best_c;
          cur_d    = full;
          colour_d = 5'd0;
          state_d  = ST_TR_RD;
        end else begin
          mask_d  = mask_inc;
          sub_d   = mask_inc;
          best_d  = n_eff + 5'd1;
          pick_d  = mask_inc & (~mask_inc + 1'b1);
          state_d = ST_DP_RD;
        end
      end
      ST_TR_RD: begin
        state_d = ST_TR_WR;
      end
      ST_TR_WR: begin
        if (cls == '0) begin
          emit_k_d = 5'd0;
          state_d  = ST_EMIT;
        end else begin
          for (int i = 0; i < NV; i++) begin
            if (cls[i]) colour_of_d[i] = colour_q[3:0];
          end
          cur_d    = cur_q ^ cls;
          colour_d = colour_q + 5'd1;
          emit_k_d = 5'd0;
          state_d  = (cur_d == '0) ? ST_EMIT : ST_TR_RD;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          out_load = 1'b1;
          if (emit_k_q == n_eff) begin
            for (int i = 0; i < NV; i++) adj_d[i] = '0;
            state_d = ST_IDLE;
          end else begin
            emit_k_d = emit_k_q + 5'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      vcount_q  <= VCOUNT_RESET;
      p_valid_q <= 1'b0;
      for (int i = 0; i < NV; i++) adj_q[i] <= '0;
    end else begin
      state_q   <= state_d;
      p_valid_q <= p_valid_d;
      adj_q     <= adj_d;
      if (cfg_we_i) vcount_q <= cfg_data_i;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    colour_of_q <= colour_of_d;
    mask_q      <= mask_d;
    sub_q       <= sub_d;
    cur_q       <= cur_d;
    pick_q      <= pick_d;
    best_q      <= best_d;
    chrom_q     <= chrom_d;
    colour_q    <= colour_d;
    emit_k_q    <= emit_k_d;
  end

  cnsd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (out_load),
    .item_i      (out_item),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // A pending submask read always comes from the submask issue state.
  a_pending_from_dp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q |-> $past(state_q) == ST_DP_RD)
    else $error("pending submask read without issue");

  // Loading the final result returns the block to idle.
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_item.last) |=> state_q == ST_IDLE)
    else $error("block not idle after final result");

  // The result counter never passes the vertex count.
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> emit_k_q <= n_eff)
    else $error("result counter out of range");

endmodule

[dv/chromatic_number_subset_dp_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chromatic_number_subset_dp_test: self-checking bench for the subset solver
// Loads random and directed graphs across several vertex counts, predicts
// the chromatic number and trace-back colouring, and checks every result.
// ---------------------------------------------------------------------------
module chromatic_number_subset_dp_test;
  import cnsd_pkg::*;

  // Largest count that is actually solved; bigger graphs only load edges.
  localparam int unsigned SOLVE_CAP = 11;

  // Predicts results from accepted transfers and checks the output stream.
  class colouring_scoreboard;
    logic [15:0] adj_rows [16];
    logic [4:0]  vcount;
    out_item_t   expected_results [$];
    int unsigned mismatches;

    function new();
      foreach (adj_rows[i]) adj_rows[i] = '0;
      vcount = VCOUNT_RESET;
      mismatches = 0;
    endfunction

    function int unsigned eff_count();
      int unsigned n;
      n = vcount;
      if (n < 1) n = 1;
      if (n > 16) n = 16;
      return n;
    endfunction

    function void set_count(logic [4:0] v);
      vcount = v;
    endfunction

    // Appends one predicted result to the tail of the queue.
    function void add_expected(out_item_t r);
      expected_results = {expected_results, r};
    endfunction

    function void note_transfer(in_item_t it);
      int unsigned n, full, mask, rest, low, idx, sub, best, pick, c, cur, colour;
      bit indep [];
      int unsigned mincol [];
      int unsigned bestcls [];
      int unsigned colour_of [16];
      out_item_t r;
      n = eff_count();
      if (it.op == OP_EDGE) begin
        if (it.vertex_a != it.vertex_b && it.vertex_a < n && it.vertex_b < n) begin
          adj_rows[it.vertex_a][it.vertex_b] = 1'b1;
          adj_rows[it.vertex_b][it.vertex_a] = 1'b1;
        end
        return;
      end
      full = (1 << n) - 1;
      indep = new[full + 1];
      mincol = new[full + 1];
      bestcls = new[full + 1];
      indep[0] = 1'b1;
      mincol[0] = 0;
      bestcls[0] = 0;
      // Independent sets built up by dropping the lowest vertex.
      for (mask = 1; mask <= full; mask++) begin
        rest = mask & (mask - 1);
        low = mask ^ rest;
        idx = $clog2(low);
        indep[mask] = indep[rest] && ((adj_rows[idx] & rest[15:0]) == 0);
      end
      // Exact DP over submasks, strictly better choices only.
      for (mask = 1; mask <= full; mask++) begin
        best = n + 1;
        pick = mask & (~mask + 1);
        for (sub = mask; sub != 0; sub = (sub - 1) & mask) begin
          if (indep[sub]) begin
            c = 1 + mincol[mask ^ sub];
            if (c < best) begin
              best = c;
              pick = sub;
            end
          end
        end
        mincol[mask] = best;
        bestcls[mask] = pick;
      end
      // Peel the kept classes off the full mask.
      foreach (colour_of[i]) colour_of[i] = 0;
      cur = full;
      colour = 0;
      while (cur != 0) begin
        c = bestcls[cur] & cur;
        if (c == 0) break;
        for (int unsigned v = 0; v < n; v++)
          if (c[v]) colour_of[v] = colour;
        cur ^= c;
        colour++;
      end
      r.kind = KIND_COUNT;
      r.vertex = '0;
      r.value = mincol[full][4:0];
      r.last = 1'b0;
      add_expected(r);
      for (int unsigned v = 0; v < n; v++) begin
        r.kind = KIND_COLOUR;
        r.vertex = v[3:0];
        r.value = colour_of[v][4:0];
        r.last = (v + 1 == n);
        add_expected(r);
      end
      foreach (adj_rows[i]) adj_rows[i] = '0;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d vertex %0d value %0d last %0d",
                   got.kind, got.vertex, got.value, got.last);
        return;
      end
      want = expected_results.pop_front();
      if (got.kind !== want.kind || got.vertex !== want.vertex ||
          got.value !== want.value || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: expected kind %0d vertex %0d value %0d last %0d,",
                    " got kind %0d vertex %0d value %0d last %0d"},
                   want.kind, want.vertex, want.value, want.last,
                   got.kind, got.vertex, got.value, got.last);
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [4:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  in_item_t   in_item_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_item_t  out_item_o;

  colouring_scoreboard sb = new();
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;

  chromatic_number_subset_dp dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #2 clk_i = ~clk_i;

  // Receiver: checks each transfer, stalls at random, with one long hold-off.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_item_o);
    if (cycle_count >= 3000 && cycle_count < 3400)
      out_stall_i <= 1'b1;
    else if (cycle_count >= 6000 && cycle_count < 9000)
      out_stall_i <= 1'b0;
    else
      out_stall_i <= ($urandom_range(99) < 20);
  end

  // Offers an item, after a random gap save for items 150-199, and awaits its transfer.
  task automatic send_item(logic op, logic [3:0] a, logic [3:0] b);
    in_item_t it;
    it.op = op;
    it.vertex_a = a;
    it.vertex_b = b;
    if (!(items_sent >= 150 && items_sent < 200)) begin
      while ($urandom_range(99) < 20) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_transfer(it);
    items_sent++;
  endtask

  // Waits for the block to go quiet, then writes the vertex count.
  task automatic write_count(logic [4:0] v);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_count(v);
  endtask

  // Random graph traffic for the current count; large counts only load edges.
  task automatic random_phase(int unsigned count);
    int unsigned n, solves;
    logic [3:0] a, b;
    n = sb.eff_count();
    solves = 0;
    for (int unsigned i = 0; i < count; i++) begin
      a = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(n - 1));
      b = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(n - 1));
      if (n <= SOLVE_CAP && (n < 9 || solves == 0) &&
          ($urandom_range(7) == 0 || i + 1 == count)) begin
        send_item(OP_SOLVE, a, b);
        solves++;
      end else begin
        send_item(OP_EDGE, a, b);
      end
    end
  endtask

  initial begin
    logic [4:0] plan [12] = '{5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd20, 5'd7,
                              5'd3, 5'd5, 5'd11, 5'd8, 5'd4};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset-count edges, self-loop, single-vertex and small-cycle solves, count 31.
    send_item(OP_EDGE, 4'd0, 4'd15);
    send_item(OP_EDGE, 4'd15, 4'd0);
    send_item(OP_EDGE, 4'd3, 4'd3);
    write_count(5'd0);
    send_item(OP_EDGE, 4'd0, 4'd1);
    send_item(OP_SOLVE, 4'd15, 4'd15);
    write_count(5'd1);
    send_item(OP_SOLVE, 4'd0, 4'd0);
    write_count(5'd3);
    send_item(OP_EDGE, 4'd0, 4'd1);
    send_item(OP_EDGE, 4'd1, 4'd2);
    send_item(OP_EDGE, 4'd2, 4'd0);
    send_item(OP_EDGE, 4'd2, 4'd3);
    send_item(OP_SOLVE, 4'd0, 4'd0);
    send_item(OP_SOLVE, 4'd0, 4'd0);
    write_count(5'd4);
    send_item(OP_EDGE, 4'd0, 4'd1);
    send_item(OP_EDGE, 4'd1, 4'd2);
    send_item(OP_EDGE, 4'd2, 4'd3);
    send_item(OP_EDGE, 4'd3, 4'd0);
    send_item(OP_SOLVE, 4'd0, 4'd0);
    write_count(5'd31);
    send_item(OP_EDGE, 4'd15, 4'd14);
    send_item(OP_EDGE, 4'd1, 4'd0);

    // Random phases across the count settings.
    foreach (plan[p]) begin
      write_count(plan[p]);
      random_phase(28);
    end

    in_valid_i <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Watchdog.
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[files.f]
rtl/core/cnsd_pkg.sv
rtl/core/cnsd_out_stage.sv
rtl/core/chromatic_number_subset_dp.sv
dv/chromatic_number_subset_dp_test.sv
